// ----- src/rvdec_pkg.sv -----
// ----------------------------------------------------------------------------
// rvdec_pkg
// shared types and encodings for the rv32i instruction decoder
// ----------------------------------------------------------------------------
package rvdec_pkg;

   // major opcodes, instruction bits 6:0
   localparam logic [6:0] OPC_REG    = 7'h33;
   localparam logic [6:0] OPC_IMM    = 7'h13;
   localparam logic [6:0] OPC_LOAD   = 7'h03;
   localparam logic [6:0] OPC_STORE  = 7'h23;
   localparam logic [6:0] OPC_BRANCH = 7'h63;
   localparam logic [6:0] OPC_LUI    = 7'h37;
   localparam logic [6:0] OPC_AUIPC  = 7'h17;
   localparam logic [6:0] OPC_JAL    = 7'h6F;
   localparam logic [6:0] OPC_JALR   = 7'h67;
   localparam logic [6:0] OPC_SYSTEM = 7'h73;

   // funct3 values
   localparam logic [2:0] F3_0 = 3'h0;
   localparam logic [2:0] F3_1 = 3'h1;
   localparam logic [2:0] F3_2 = 3'h2;
   localparam logic [2:0] F3_3 = 3'h3;
   localparam logic [2:0] F3_4 = 3'h4;
   localparam logic [2:0] F3_5 = 3'h5;
   localparam logic [2:0] F3_6 = 3'h6;
   localparam logic [2:0] F3_7 = 3'h7;

   // funct7 values
   localparam logic [6:0] F7_BASE = 7'h00;
   localparam logic [6:0] F7_ALT  = 7'h20;

   // exact system words
   localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
   localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

   // dense operation numbers
   localparam logic [5:0] OP_ADD    = 6'd0;
   localparam logic [5:0] OP_SUB    = 6'd1;
   localparam logic [5:0] OP_XOR    = 6'd2;
   localparam logic [5:0] OP_OR     = 6'd3;
   localparam logic [5:0] OP_AND    = 6'd4;
   localparam logic [5:0] OP_SLL    = 6'd5;
   localparam logic [5:0] OP_SRL    = 6'd6;
   localparam logic [5:0] OP_SRA    = 6'd7;
   localparam logic [5:0] OP_SLT    = 6'd8;
   localparam logic [5:0] OP_SLTU   = 6'd9;
   localparam logic [5:0] OP_ADDI   = 6'd10;
   localparam logic [5:0] OP_XORI   = 6'd11;
   localparam logic [5:0] OP_ORI    = 6'd12;
   localparam logic [5:0] OP_ANDI   = 6'd13;
   localparam logic [5:0] OP_SLTI   = 6'd14;
   localparam logic [5:0] OP_SLTIU  = 6'd15;
   localparam logic [5:0] OP_SLLI   = 6'd16;
   localparam logic [5:0] OP_SRLI   = 6'd17;
   localparam logic [5:0] OP_SRAI   = 6'd18;
   localparam logic [5:0] OP_LB     = 6'd19;
   localparam logic [5:0] OP_LH     = 6'd20;
   localparam logic [5:0] OP_LW     = 6'd21;
   localparam logic [5:0] OP_LBU    = 6'd22;
   localparam logic [5:0] OP_LHU    = 6'd23;
   localparam logic [5:0] OP_SB     = 6'd24;
   localparam logic [5:0] OP_SH     = 6'd25;
   localparam logic [5:0] OP_SW     = 6'd26;
   localparam logic [5:0] OP_BEQ    = 6'd27;
   localparam logic [5:0] OP_BNE    = 6'd28;
   localparam logic [5:0] OP_BLT    = 6'd29;
   localparam logic [5:0] OP_BGE    = 6'd30;
   localparam logic [5:0] OP_BLTU   = 6'd31;
   localparam logic [5:0] OP_BGEU   = 6'd32;
   localparam logic [5:0] OP_LUI    = 6'd33;
   localparam logic [5:0] OP_AUIPC  = 6'd34;
   localparam logic [5:0] OP_JAL    = 6'd35;
   localparam logic [5:0] OP_JALR   = 6'd36;
   localparam logic [5:0] OP_ECALL  = 6'd37;
   localparam logic [5:0] OP_EBREAK = 6'd38;

   // one decoded instruction
   typedef struct packed {
      logic               legal;
      logic [5:0]         op_code;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg_one;
      logic [4:0]         src_reg_two;
      logic signed [31:0] immediate;
   } decode_result_type;

endpackage

// ----- src/rvdec_decode.sv -----
// ----------------------------------------------------------------------------
// rvdec_decode
// combinational field extraction and operation lookup for one rv32i word
// ----------------------------------------------------------------------------
module rvdec_decode (
   input  logic [31:0]                instr_word,
   output rvdec_pkg::decode_result_type result
);
   import rvdec_pkg::*;

   logic [6:0]  opc;
   logic [4:0]  rd;
   logic [2:0]  f3;
   logic [4:0]  rs1;
   logic [4:0]  rs2;
   logic [6:0]  f7;
   logic [31:0] imm_i;
   logic [31:0] imm_s;
   logic [31:0] imm_b;
   logic [31:0] imm_u;
   logic [31:0] imm_j;
   logic [31:0] imm_shamt;
   logic        ok;
   logic [5:0]  op;

   assign opc       = instr_word[6:0];
   assign rd        = instr_word[11:7];
   assign f3        = instr_word[14:12];
   assign rs1       = instr_word[19:15];
   assign rs2       = instr_word[24:20];
   assign f7        = instr_word[31:25];
   assign imm_i     = {{20{instr_word[31]}}, instr_word[31:20]};
   assign imm_s     = {{20{instr_word[31]}}, instr_word[31:25], instr_word[11:7]};
   assign imm_b     = {{20{instr_word[31]}}, instr_word[7], instr_word[30:25],
                       instr_word[11:8], 1'b0};
   assign imm_u     = {instr_word[31:12], 12'h000};
   assign imm_j     = {{12{instr_word[31]}}, instr_word[19:12], instr_word[20],
                       instr_word[30:21], 1'b0};
   assign imm_shamt = {27'd0, rs2};

   always_comb begin
      ok     = 1'b0;
      op     = OP_ADD;
      result = '0;
      unique case (opc)
         OPC_REG: begin
            if (f7 == F7_BASE) begin
               ok = 1'b1;
               unique case (f3)
                  F3_0:    op = OP_ADD;
                  F3_1:    op = OP_SLL;
                  F3_2:    op = OP_SLT;
                  F3_3:    op = OP_SLTU;
                  F3_4:    op = OP_XOR;
                  F3_5:    op = OP_SRL;
                  F3_6:    op = OP_OR;
                  default: op = OP_AND;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_0) begin
               ok = 1'b1;
               op = OP_SUB;
            end else if (f7 == F7_ALT && f3 == F3_5) begin
               ok = 1'b1;
               op = OP_SRA;
            end
            result.dest_reg    = rd;
            result.src_reg_one = rs1;
            result.src_reg_two = rs2;
         end
         OPC_IMM: begin
            result.dest_reg    = rd;
            result.src_reg_one = rs1;
            result.immediate   = imm_i;
            unique case (f3)
               F3_0: begin ok = 1'b1; op = OP_ADDI;  end
               F3_2: begin ok = 1'b1; op = OP_SLTI;  end
               F3_3: begin ok = 1'b1; op = OP_SLTIU; end
               F3_4: begin ok = 1'b1; op = OP_XORI;  end
               F3_6: begin ok = 1'b1; op = OP_ORI;   end
               F3_7: begin ok = 1'b1; op = OP_ANDI;  end
               F3_1: begin
                  result.immediate = imm_shamt;
                  ok = (f7 == F7_BASE);
                  op = OP_SLLI;
               end
               default: begin
                  // shift right, logical or arithmetic by funct7
                  result.immediate = imm_shamt;
                  ok = (f7 == F7_BASE) || (f7 == F7_ALT);
                  op = (f7 == F7_ALT) ? OP_SRAI : OP_SRLI;
               end
            endcase
         end
         OPC_LOAD: begin
            result.dest_reg    = rd;
            result.src_reg_one = rs1;
            result.immediate   = imm_i;
            unique case (f3)
               F3_0:    begin ok = 1'b1; op = OP_LB;  end
               F3_1:    begin ok = 1'b1; op = OP_LH;  end
               F3_2:    begin ok = 1'b1; op = OP_LW;  end
               F3_4:    begin ok = 1'b1; op = OP_LBU; end
               F3_5:    begin ok = 1'b1; op = OP_LHU; end
               default: ok = 1'b0;
            endcase
         end
         OPC_STORE: begin
            result.src_reg_one = rs1;
            result.src_reg_two = rs2;
            result.immediate   = imm_s;
            unique case (f3)
               F3_0:    begin ok = 1'b1; op = OP_SB; end
               F3_1:    begin ok = 1'b1; op = OP_SH; end
               F3_2:    begin ok = 1'b1; op = OP_SW; end
               default: ok = 1'b0;
            endcase
         end
         OPC_BRANCH: begin
            result.src_reg_one = rs1;
            result.src_reg_two = rs2;
            result.immediate   = imm_b;
            unique case (f3)
               F3_0:    begin ok = 1'b1; op = OP_BEQ;  end
               F3_1:    begin ok = 1'b1; op = OP_BNE;  end
               F3_4:    begin ok = 1'b1; op = OP_BLT;  end
               F3_5:    begin ok = 1'b1; op = OP_BGE;  end
               F3_6:    begin ok = 1'b1; op = OP_BLTU; end
               F3_7:    begin ok = 1'b1; op = OP_BGEU; end
               default: ok = 1'b0;
            endcase
         end
         OPC_LUI: begin
            ok = 1'b1;
            op = OP_LUI;
            result.dest_reg  = rd;
            result.immediate = imm_u;
         end
         OPC_AUIPC: begin
            ok = 1'b1;
            op = OP_AUIPC;
            result.dest_reg  = rd;
            result.immediate = imm_u;
         end
         OPC_JAL: begin
            ok = 1'b1;
            op = OP_JAL;
            result.dest_reg  = rd;
            result.immediate = imm_j;
         end
         OPC_JALR: begin
            ok = (f3 == F3_0);
            op = OP_JALR;
            result.dest_reg    = rd;
            result.src_reg_one = rs1;
            result.immediate   = imm_i;
         end
         OPC_SYSTEM: begin
            if (instr_word == WORD_ECALL) begin
               ok = 1'b1;
               op = OP_ECALL;
            end else if (instr_word == WORD_EBREAK) begin
               ok = 1'b1;
               op = OP_EBREAK;
            end
         end
         default: ok = 1'b0;
      endcase

      // illegal words come out all zero
      if (ok) begin
         result.legal   = 1'b1;
         result.op_code = op;
      end else begin
         result = '0;
      end
   end

endmodule

// ----- src/rv32i_instruction_decoder.sv -----
// ----------------------------------------------------------------------------
// rv32i_instruction_decoder
// two-register rv32i decoder: request register, decode logic, response register
// ----------------------------------------------------------------------------
// Decodes one 32-bit RV32I instruction word per request into a legal flag, a
// dense operation number, rd/rs1/rs2 and the assembled immediate. A request
// is taken into the request register, decoded by shallow combinational logic,
// and the result lands in the response register, which drives rsp_valid. One
// request is accepted every cycle while the response side does not stall. A
// response stall holds the response register only; the request register still
// takes one more request, so req_stall follows rsp_stall only when both stages
// hold data. FENCE, CSR and every other unsupported or reserved encoding give
// legal low with all other fields zero. Stores put the data register in
// src_reg_two, shift-immediates put the shift amount in the immediate, and
// lui/auipc return instr_word[31:12] shifted up by twelve.
module rv32i_instruction_decoder (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [31:0]        req_instr_word,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_legal,
   output logic [5:0]         rsp_op_code,
   output logic [4:0]         rsp_dest_reg,
   output logic [4:0]         rsp_src_reg_one,
   output logic [4:0]         rsp_src_reg_two,
   output logic signed [31:0] rsp_immediate
);
   import rvdec_pkg::*;

   // request register
   logic              req_full_ff;
   logic              req_full_in;
   logic [31:0]       word_ff;
   logic [31:0]       word_in;

   // response register
   logic              rsp_full_ff;
   logic              rsp_full_in;
   decode_result_type rsp_data_ff;
   decode_result_type rsp_data_in;

   decode_result_type decoded;
   logic              rsp_hold;
   logic              req_hold;
   logic              req_take;

   // shallow decode between the two registers
   rvdec_decode u_decode (
      .instr_word (word_ff),
      .result     (decoded)
   );

   // a stage holds when it has data and the next one cannot take it
   assign rsp_hold  = rsp_full_ff && rsp_stall;
   assign req_hold  = req_full_ff && rsp_hold;
   assign req_stall = req_hold;
   assign req_take  = req_valid && !req_hold;

   always_comb begin
      req_full_in = req_full_ff;
      word_in     = word_ff;
      rsp_full_in = rsp_full_ff;
      rsp_data_in = rsp_data_ff;
      if (!rsp_hold) begin
         // response register moves: load decoded word or go empty
         rsp_full_in = req_full_ff;
         rsp_data_in = decoded;
      end
      if (!req_hold) begin
         req_full_in = req_take;
         word_in     = req_instr_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_full_ff <= 1'b0;
         rsp_full_ff <= 1'b0;
      end else begin
         req_full_ff <= req_full_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      word_ff     <= word_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid       = rsp_full_ff;
   assign rsp_legal       = rsp_data_ff.legal;
   assign rsp_op_code     = rsp_data_ff.op_code;
   assign rsp_dest_reg    = rsp_data_ff.dest_reg;
   assign rsp_src_reg_one = rsp_data_ff.src_reg_one;
   assign rsp_src_reg_two = rsp_data_ff.src_reg_two;
   assign rsp_immediate   = rsp_data_ff.immediate;

endmodule

// ----- bench/tb_rv32i_instruction_decoder.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rv32i_instruction_decoder
// self-checking bench for the rv32i instruction decoder
// ----------------------------------------------------------------------------
// Drives instruction words through the request channel and checks every
// decoded response against an in-bench decode of the same word. A short
// directed pass hits the encoding corners, then mostly well-formed random
// instructions run under three idle mixes, plus one long response hold-off
// that backs the pipeline up into the request side.
module tb_rv32i_instruction_decoder;
   import rvdec_pkg::*;

   // opcode only used to build a fence word, the decoder rejects it
   localparam logic [6:0] OPC_FENCE    = 7'h0F;
   localparam int         CYCLE_LIMIT  = 200000;
   localparam int         DRAIN_CYCLES = 4;
   localparam int         HOLD_CYCLES  = 60;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [31:0]        req_instr_word;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic               rsp_legal;
   logic [5:0]         rsp_op_code;
   logic [4:0]         rsp_dest_reg;
   logic [4:0]         rsp_src_reg_one;
   logic [4:0]         rsp_src_reg_two;
   logic signed [31:0] rsp_immediate;

   // decodes waiting for their response, oldest first
   decode_result_type pending_decodes[$];

   int   error_count   = 0;
   int   cycle_count   = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic long_hold     = 1'b0;
   event start_long_hold;

   rv32i_instruction_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_instr_word  (req_instr_word),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_legal       (rsp_legal),
      .rsp_op_code     (rsp_op_code),
      .rsp_dest_reg    (rsp_dest_reg),
      .rsp_src_reg_one (rsp_src_reg_one),
      .rsp_src_reg_two (rsp_src_reg_two),
      .rsp_immediate   (rsp_immediate)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // expected decode of one word
   // ---------------------------------------------------------------------
   function automatic decode_result_type decode_expected(input logic [31:0] word);
      decode_result_type d;
      logic [6:0]  opc;
      logic [6:0]  f7;
      logic [2:0]  f3;
      logic [4:0]  rd;
      logic [4:0]  rs1;
      logic [4:0]  rs2;
      logic [31:0] imm_i;
      logic [31:0] imm_s;
      logic [31:0] imm_b;
      logic [31:0] imm_j;
      opc   = word[6:0];
      rd    = word[11:7];
      f3    = word[14:12];
      rs1   = word[19:15];
      rs2   = word[24:20];
      f7    = word[31:25];
      imm_i = {{20{word[31]}}, word[31:20]};
      imm_s = {{20{word[31]}}, word[31:25], word[11:7]};
      imm_b = {{19{word[31]}}, word[31], word[7], word[30:25], word[11:8], 1'b0};
      imm_j = {{11{word[31]}}, word[31], word[19:12], word[20], word[30:21], 1'b0};
      d = '0;
      case (opc)
         OPC_REG: begin
            d = '{1'b1, OP_ADD, rd, rs1, rs2, 32'sd0};
            if (f7 == F7_BASE) begin
               case (f3)
                  F3_0: d.op_code = OP_ADD;
                  F3_1: d.op_code = OP_SLL;
                  F3_2: d.op_code = OP_SLT;
                  F3_3: d.op_code = OP_SLTU;
                  F3_4: d.op_code = OP_XOR;
                  F3_5: d.op_code = OP_SRL;
                  F3_6: d.op_code = OP_OR;
                  default: d.op_code = OP_AND;
               endcase
            end else if (f7 == F7_ALT && f3 == F3_0) begin
               d.op_code = OP_SUB;
            end else if (f7 == F7_ALT && f3 == F3_5) begin
               d.op_code = OP_SRA;
            end else begin
               d.legal = 1'b0;
            end
         end
         OPC_IMM: begin
            d = '{1'b1, OP_ADDI, rd, rs1, 5'd0, imm_i};
            case (f3)
               F3_0: d.op_code = OP_ADDI;
               F3_2: d.op_code = OP_SLTI;
               F3_3: d.op_code = OP_SLTIU;
               F3_4: d.op_code = OP_XORI;
               F3_6: d.op_code = OP_ORI;
               F3_7: d.op_code = OP_ANDI;
               default: begin
                  // shift-immediate: amount goes out zero-extended
                  d.immediate = {27'd0, rs2};
                  if (f3 == F3_1 && f7 == F7_BASE) d.op_code = OP_SLLI;
                  else if (f3 == F3_5 && f7 == F7_BASE) d.op_code = OP_SRLI;
                  else if (f3 == F3_5 && f7 == F7_ALT) d.op_code = OP_SRAI;
                  else d.legal = 1'b0;
               end
            endcase
         end
         OPC_LOAD: begin
            d = '{1'b1, OP_LB, rd, rs1, 5'd0, imm_i};
            case (f3)
               F3_0: d.op_code = OP_LB;
               F3_1: d.op_code = OP_LH;
               F3_2: d.op_code = OP_LW;
               F3_4: d.op_code = OP_LBU;
               F3_5: d.op_code = OP_LHU;
               default: d.legal = 1'b0;
            endcase
         end
         OPC_STORE: begin
            d = '{1'b1, OP_SB, 5'd0, rs1, rs2, imm_s};
            case (f3)
               F3_0: d.op_code = OP_SB;
               F3_1: d.op_code = OP_SH;
               F3_2: d.op_code = OP_SW;
               default: d.legal = 1'b0;
            endcase
         end
         OPC_BRANCH: begin
            d = '{1'b1, OP_BEQ, 5'd0, rs1, rs2, imm_b};
            case (f3)
               F3_0: d.op_code = OP_BEQ;
               F3_1: d.op_code = OP_BNE;
               F3_4: d.op_code = OP_BLT;
               F3_5: d.op_code = OP_BGE;
               F3_6: d.op_code = OP_BLTU;
               F3_7: d.op_code = OP_BGEU;
               default: d.legal = 1'b0;
            endcase
         end
         OPC_LUI:   d = '{1'b1, OP_LUI, rd, 5'd0, 5'd0, {word[31:12], 12'd0}};
         OPC_AUIPC: d = '{1'b1, OP_AUIPC, rd, 5'd0, 5'd0, {word[31:12], 12'd0}};
         OPC_JAL:   d = '{1'b1, OP_JAL, rd, 5'd0, 5'd0, imm_j};
         OPC_JALR:  d = '{f3 == F3_0, OP_JALR, rd, rs1, 5'd0, imm_i};
         OPC_SYSTEM: begin
            // only the two exact system words are supported
            if (word == WORD_ECALL) d.op_code = OP_ECALL;
            else if (word == WORD_EBREAK) d.op_code = OP_EBREAK;
            d.legal = (word == WORD_ECALL) || (word == WORD_EBREAK);
         end
         default: d.legal = 1'b0;
      endcase
      // an illegal word clears every field
      if (!d.legal) d = '0;
      return d;
   endfunction

   // ---------------------------------------------------------------------
   // random instruction words
   // ---------------------------------------------------------------------
   // well-formed word for one operation, random registers and immediate
   function automatic logic [31:0] random_legal_word(input logic [5:0] op);
      logic [31:0] w;
      logic [18:0] sel;   // {fix_f7, fix_f3, f7, f3, opcode}
      w = $urandom();
      case (op)
         OP_ADD:   sel = {2'b11, F7_BASE, F3_0, OPC_REG};
         OP_SUB:   sel = {2'b11, F7_ALT,  F3_0, OPC_REG};
         OP_XOR:   sel = {2'b11, F7_BASE, F3_4, OPC_REG};
         OP_OR:    sel = {2'b11, F7_BASE, F3_6, OPC_REG};
         OP_AND:   sel = {2'b11, F7_BASE, F3_7, OPC_REG};
         OP_SLL:   sel = {2'b11, F7_BASE, F3_1, OPC_REG};
         OP_SRL:   sel = {2'b11, F7_BASE, F3_5, OPC_REG};
         OP_SRA:   sel = {2'b11, F7_ALT,  F3_5, OPC_REG};
         OP_SLT:   sel = {2'b11, F7_BASE, F3_2, OPC_REG};
         OP_SLTU:  sel = {2'b11, F7_BASE, F3_3, OPC_REG};
         OP_ADDI:  sel = {2'b01, F7_BASE, F3_0, OPC_IMM};
         OP_XORI:  sel = {2'b01, F7_BASE, F3_4, OPC_IMM};
         OP_ORI:   sel = {2'b01, F7_BASE, F3_6, OPC_IMM};
         OP_ANDI:  sel = {2'b01, F7_BASE, F3_7, OPC_IMM};
         OP_SLTI:  sel = {2'b01, F7_BASE, F3_2, OPC_IMM};
         OP_SLTIU: sel = {2'b01, F7_BASE, F3_3, OPC_IMM};
         OP_SLLI:  sel = {2'b11, F7_BASE, F3_1, OPC_IMM};
         OP_SRLI:  sel = {2'b11, F7_BASE, F3_5, OPC_IMM};
         OP_SRAI:  sel = {2'b11, F7_ALT,  F3_5, OPC_IMM};
         OP_LB:    sel = {2'b01, F7_BASE, F3_0, OPC_LOAD};
         OP_LH:    sel = {2'b01, F7_BASE, F3_1, OPC_LOAD};
         OP_LW:    sel = {2'b01, F7_BASE, F3_2, OPC_LOAD};
         OP_LBU:   sel = {2'b01, F7_BASE, F3_4, OPC_LOAD};
         OP_LHU:   sel = {2'b01, F7_BASE, F3_5, OPC_LOAD};
         OP_SB:    sel = {2'b01, F7_BASE, F3_0, OPC_STORE};
         OP_SH:    sel = {2'b01, F7_BASE, F3_1, OPC_STORE};
         OP_SW:    sel = {2'b01, F7_BASE, F3_2, OPC_STORE};
         OP_BEQ:   sel = {2'b01, F7_BASE, F3_0, OPC_BRANCH};
         OP_BNE:   sel = {2'b01, F7_BASE, F3_1, OPC_BRANCH};
         OP_BLT:   sel = {2'b01, F7_BASE, F3_4, OPC_BRANCH};
         OP_BGE:   sel = {2'b01, F7_BASE, F3_5, OPC_BRANCH};
         OP_BLTU:  sel = {2'b01, F7_BASE, F3_6, OPC_BRANCH};
         OP_BGEU:  sel = {2'b01, F7_BASE, F3_7, OPC_BRANCH};
         OP_LUI:   sel = {2'b00, F7_BASE, F3_0, OPC_LUI};
         OP_AUIPC: sel = {2'b00, F7_BASE, F3_0, OPC_AUIPC};
         OP_JAL:   sel = {2'b00, F7_BASE, F3_0, OPC_JAL};
         OP_JALR:  sel = {2'b01, F7_BASE, F3_0, OPC_JALR};
         OP_ECALL: return WORD_ECALL;
         default:  return WORD_EBREAK;
      endcase
      w[6:0] = sel[6:0];
      if (sel[17]) w[14:12] = sel[9:7];
      if (sel[18]) w[31:25] = sel[16:10];
      return w;
   endfunction

   function automatic logic [31:0] random_instruction();
      logic [31:0] w;
      int          pick;
      pick = $urandom_range(99);
      w    = random_legal_word(6'($urandom_range(OP_EBREAK)));
      if (pick >= 94) begin
         // pure noise
         w = $urandom();
      end else if (pick >= 88) begin
         // known opcode, everything else random
         w = $urandom();
         case ($urandom_range(9))
            0: w[6:0] = OPC_REG;
            1: w[6:0] = OPC_IMM;
            2: w[6:0] = OPC_LOAD;
            3: w[6:0] = OPC_STORE;
            4: w[6:0] = OPC_BRANCH;
            5: w[6:0] = OPC_LUI;
            6: w[6:0] = OPC_AUIPC;
            7: w[6:0] = OPC_JAL;
            8: w[6:0] = OPC_JALR;
            default: w[6:0] = OPC_SYSTEM;
         endcase
      end else if (pick >= 76) begin
         // near miss: one flipped bit in a well-formed word
         w[$urandom_range(31)] ^= 1'b1;
      end
      return w;
   endfunction

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------
   // offer one word, hold it until accepted, then queue its decode
   task automatic send_instruction(input logic [31:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_instr_word <= word;
      do @(posedge clock); while (req_stall);
      pending_decodes.push_back(decode_expected(word));
   endtask

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------
   // random stall, forced high during a long hold-off
   always @(posedge clock) begin
      rsp_stall <= long_hold || ($urandom_range(99) < recv_idle_pct);
   end

   // long hold-off, counted here so the sender keeps pushing meanwhile
   always begin
      @(start_long_hold);
      long_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         error_count++;
      end
   endtask

   // compare each accepted response with the oldest pending decode
   always @(posedge clock) begin
      decode_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_decodes.size() == 0) begin
            $display("%0t: response with no request pending, expected none, actual %h",
                     $time, {rsp_legal, rsp_op_code, rsp_dest_reg, rsp_src_reg_one,
                             rsp_src_reg_two, rsp_immediate});
            error_count++;
         end else begin
            want = pending_decodes.pop_front();
            check_field("legal", 32'(want.legal), 32'(rsp_legal));
            check_field("op_code", 32'(want.op_code), 32'(rsp_op_code));
            check_field("dest_reg", 32'(want.dest_reg), 32'(rsp_dest_reg));
            check_field("src_reg_one", 32'(want.src_reg_one), 32'(rsp_src_reg_one));
            check_field("src_reg_two", 32'(want.src_reg_two), 32'(rsp_src_reg_two));
            check_field("immediate", want.immediate, rsp_immediate);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------
   // encoding corners, system words and reserved encodings
   task automatic test_directed_words();
      send_instruction(32'h0000_0000);
      send_instruction(32'hFFFF_FFFF);
      send_instruction(WORD_ECALL);
      send_instruction(WORD_EBREAK);
      send_instruction(WORD_EBREAK | 32'h0010_0000);                // same ebreak word again
      send_instruction({12'h300, 5'd1, F3_1, 5'd2, OPC_SYSTEM});     // csr access
      send_instruction({4'h0, 4'hF, 4'hF, 5'd0, F3_0, 5'd0, OPC_FENCE});
      send_instruction({F7_BASE, 5'd31, 5'd31, F3_0, 5'd31, OPC_REG});
      send_instruction({F7_ALT, 5'd1, 5'd2, F3_0, 5'd3, OPC_REG});
      send_instruction({F7_ALT, 5'd4, 5'd5, F3_5, 5'd6, OPC_REG});
      send_instruction({7'h01, 5'd4, 5'd5, F3_0, 5'd6, OPC_REG});    // bad funct7
      send_instruction({12'h7FF, 5'd1, F3_0, 5'd2, OPC_IMM});
      send_instruction({12'h800, 5'd31, F3_3, 5'd0, OPC_IMM});
      send_instruction({F7_ALT, 5'd31, 5'd7, F3_5, 5'd8, OPC_IMM});
      send_instruction({F7_ALT, 5'd31, 5'd7, F3_1, 5'd8, OPC_IMM});  // slli, bad funct7
      send_instruction({F7_BASE, 5'd0, 5'd9, F3_5, 5'd10, OPC_IMM});
      send_instruction({12'hFFF, 5'd11, F3_2, 5'd12, OPC_LOAD});
      send_instruction({12'h123, 5'd11, F3_3, 5'd12, OPC_LOAD});     // reserved load
      send_instruction({7'h40, 5'd5, 5'd6, F3_2, 5'd0, OPC_STORE});
      send_instruction({7'h3F, 5'd5, 5'd6, F3_3, 5'd31, OPC_STORE}); // reserved store
      send_instruction({1'b1, 6'h00, 5'd5, 5'd6, F3_0, 4'h0, 1'b0, OPC_BRANCH});
      send_instruction({1'b0, 6'h3F, 5'd7, 5'd8, F3_7, 4'hF, 1'b1, OPC_BRANCH});
      send_instruction({1'b0, 6'h3F, 5'd7, 5'd8, F3_2, 4'hF, 1'b1, OPC_BRANCH});
      send_instruction({20'hFFFFF, 5'd31, OPC_LUI});
      send_instruction({20'h00001, 5'd1, OPC_AUIPC});
      send_instruction({1'b1, 10'h000, 1'b0, 8'h00, 5'd1, OPC_JAL});
      send_instruction({1'b0, 10'h3FF, 1'b1, 8'hFF, 5'd0, OPC_JAL});
      send_instruction({12'h800, 5'd31, F3_0, 5'd1, OPC_JALR});
      send_instruction({12'h7FF, 5'd31, F3_1, 5'd1, OPC_JALR});      // jalr, bad funct3
   endtask

   task automatic test_random_words(input int count, input int send_pct,
                                    input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_instruction(random_instruction());
   endtask

   // hold the response side long enough to back up into the request side
   task automatic test_long_hold();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      -> start_long_hold;
      repeat (40) send_instruction(random_instruction());
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_instr_word = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_directed_words();
      test_random_words(300, 21, 77);
      test_random_words(300, 77, 21);
      test_long_hold();
      test_random_words(260, 0, 0);
      req_valid <= 1'b0;

      // drain, then keep watching the pipeline for stray responses
      while (pending_decodes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/rvdec_pkg.sv
src/rvdec_decode.sv
src/rv32i_instruction_decoder.sv
bench/tb_rv32i_instruction_decoder.sv
